/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sha256md_pkg.sv */
package sha256md_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // controls from the sequencer to the round engine
  typedef struct packed {
    logic push;   // shift a message word into the schedule window
    logic start;  // load working vars from the chain and begin 64 rounds
    logic init;   // reload chain with the initial hash
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // chain update happens at this edge
  } rnd_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* hw/rtl/sha256_message_digest.sv */
// A request is accepted only while idle; the byte that fills a block starts a compression
// (64 shared rounds plus the chain add). End of message pads the block with the marker,
// zeros and the length and compresses it; a marker at byte 56 or later needs a second
// padding block and compression. Then eight digest words leave, one per unstalled cycle.
// The input stalls during padding, compression and digest output.
// Synchronous active-low reset: initial hash, zero length, ready for a message.
`include "assert_macros.svh"

module sha256_message_digest (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha256md_pkg::in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha256md_pkg::out_t out_data
);
  import sha256md_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        first_r, first_nxt;
  logic        final_r, final_nxt;
  logic        fin_pend_r, fin_pend_nxt;
  logic        pad_mode_r, pad_mode_nxt;

  logic        wr_byte;
  logic [7:0]  byte_w;
  logic [63:0] len_sh;
  logic [31:0] push_word;
  logic [31:0] rd_word;
  rnd_ctl_t    ctl;
  rnd_sts_t    sts;

  // length byte for block positions 56..63, big-endian
  assign len_sh    = len_r >> {3'd7 - pos_r[2:0], 3'b000};
  assign push_word = {acc_r, byte_w};

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    first_nxt    = first_r;
    final_nxt    = final_r;
    fin_pend_nxt = fin_pend_r;
    pad_mode_nxt = pad_mode_r;
    wr_byte      = 1'b0;
    byte_w       = 8'h00;
    ctl          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.byte_present) begin
            wr_byte = 1'b1;
            byte_w  = in_data.data_byte;
            len_nxt = len_r + 64'd8;
            if (pos_r == LAST_POS) begin
              state_nxt    = S_COMP;
              fin_pend_nxt = in_data.end_of_message;
              pad_mode_nxt = 1'b0;
            end else if (in_data.end_of_message) begin
              state_nxt    = S_PAD;
              first_nxt    = 1'b1;
              pad_mode_nxt = 1'b1;
            end
          end else if (in_data.end_of_message) begin
            state_nxt    = S_PAD;
            first_nxt    = 1'b1;
            pad_mode_nxt = 1'b1;
          end
        end
      end
      S_PAD: begin
        wr_byte = 1'b1;
        if (first_r) begin
          byte_w    = PAD_BYTE;
          first_nxt = 1'b0;
          // length fits in this block only if the marker lands before byte 56
          final_nxt = (pos_r < LEN_POS);
        end else if (final_r && pos_r >= LEN_POS) begin
          byte_w = len_sh[7:0];
        end
        if (pos_r == LAST_POS) begin
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          if (fin_pend_r) begin
            state_nxt    = S_PAD;
            first_nxt    = 1'b1;
            pad_mode_nxt = 1'b1;
            fin_pend_nxt = 1'b0;
          end else if (pad_mode_r) begin
            if (final_r) begin
              state_nxt = S_OUT;
              idx_nxt   = 3'd0;
            end else begin
              state_nxt = S_PAD;
              final_nxt = 1'b1;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == 3'd7) begin
            ctl.init     = 1'b1;
            len_nxt      = 64'd0;
            pad_mode_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_byte) begin
      acc_nxt   = {acc_r[15:0], byte_w};
      pos_nxt   = pos_r + 6'd1;
      ctl.push  = (pos_r[1:0] == 2'd3);
      ctl.start = (pos_r == LAST_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r      <= 6'd0;
      len_r      <= 64'd0;
      idx_r      <= 3'd0;
      first_r    <= 1'b0;
      final_r    <= 1'b0;
      fin_pend_r <= 1'b0;
      pad_mode_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
      first_r    <= first_nxt;
      final_r    <= final_nxt;
      fin_pend_r <= fin_pend_nxt;
      pad_mode_r <= pad_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  sha256md_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_word (push_word),
    .rd_idx    (idx_r),
    .rd_word   (rd_word),
    .sts       (sts)
  );

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_data.digest_word = rd_word;
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 3'd7);

  `SHA_ASSERT_NOW(a_comp_busy, state_r == S_COMP, sts.busy, "waiting on idle round engine")
  `SHA_ASSERT_NOW(a_out_aligned, state_r == S_OUT, pos_r == 6'd0 && !sts.busy,
                  "digest out with partial block")
  `SHA_ASSERT_NEXT(a_last_resets, out_valid && !out_stall && out_data.last_word,
                   state_r == S_IDLE && len_r == 64'd0, "no return to idle after digest")

endmodule

/* hw/rtl/sha256md_round.sv */
`include "assert_macros.svh"

module sha256md_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256md_pkg::rnd_ctl_t ctl,
  input  logic [31:0]           push_word,
  input  logic [2:0]            rd_idx,
  output logic [31:0]           rd_word,
  output sha256md_pkg::rnd_sts_t sts
);
  import sha256md_pkg::*;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_RUN  = 2'd1;
  localparam logic [1:0] RS_ADD  = 2'd2;

  logic [1:0]  rs_r, rs_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] t1, t2, w_new, ch, maj;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // one round; w_r[0] always holds W[t]
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch + RK[rnd_r] + w_r[0];
    t2    = bsig0(v_r[0]) + maj;
    w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  end

  always_comb begin
    rs_nxt  = rs_r;
    rnd_nxt = rnd_r;
    case (rs_r)
      RS_IDLE: begin
        if (ctl.start) begin
          rs_nxt  = RS_RUN;
          rnd_nxt = 6'd0;
        end
      end
      RS_RUN: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_POS) begin
          rs_nxt = RS_ADD;
        end
      end
      RS_ADD: begin
        rs_nxt = RS_IDLE;
      end
      default: begin
        rs_nxt = RS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r  <= RS_IDLE;
      rnd_r <= 6'd0;
    end else begin
      rs_r  <= rs_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      if (!rst_n || ctl.init) begin
        h_r[i] <= IV[i];
      end else if (rs_r == RS_ADD) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (rs_r == RS_RUN) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push || rs_r == RS_RUN) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= ctl.push ? push_word : w_new;
    end
  end

  assign rd_word  = h_r[rd_idx];
  assign sts.busy = (rs_r != RS_IDLE);
  assign sts.done = (rs_r == RS_ADD);

  `SHA_ASSERT_NOW(a_start_idle, ctl.start, rs_r == RS_IDLE, "start while engine busy")
  `SHA_ASSERT_NOW(a_push_quiet, ctl.push, rs_r != RS_RUN, "window push during rounds")
  `SHA_ASSERT_NEXT(a_run_to_add, rs_r == RS_RUN && rnd_r == LAST_POS, rs_r == RS_ADD,
                   "round 63 not followed by chain update")

endmodule

/* verif/sha256_message_digest_tb.sv */
`timescale 1ns / 1ps

module sha256_message_digest_tb;
  import sha256md_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int TAIL_CYCLES    = 300;
  localparam int RANDOM_REQS    = 370;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    in_t req;
    bit  drain_first;  // sender waits for every outstanding digest word
  } byte_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  sha256_message_digest u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- digest predictor ----------------
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  out_t      digest_q [$];
  byte_req_t pending [$];

  int unsigned predicted_words = 0;
  int unsigned checked_words = 0;
  int unsigned mismatches = 0;
  int unsigned reqs_sent = 0;
  int unsigned msgs_done = 0;
  int unsigned two_block_pads = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
                                hash_state[3], hash_state[4], hash_state[5],
                                hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void sha_absorb(in_t req);
    int   pad_at;
    out_t word;
    if (req.byte_present) begin
      msg_block[blk_fill] = req.data_byte;
      msg_bits += 64'd8;
      blk_fill++;
      if (blk_fill == 6'd0) compress_block();
    end
    if (req.end_of_message) begin
      pad_at = blk_fill;
      msg_block[pad_at] = 8'h80;
      pad_at++;
      if (pad_at > 56) begin
        while (pad_at < 64) msg_block[pad_at++] = 8'h00;
        compress_block();
        pad_at = 0;
        two_block_pads++;
      end
      while (pad_at < 56) msg_block[pad_at++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        word.digest_word = hash_state[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        digest_q.push_back(word);
      end
      predicted_words += 8;
      msgs_done++;
      restart_message();
    end
  endfunction

  initial restart_message();

  // ---------------- driver ----------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : drive_reqs
    logic      next_valid;
    byte_req_t item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sha_absorb(in_data);
        reqs_sent++;
      end
      if (!in_valid || !in_stall) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain_first && predicted_words != checked_words)) begin
          item = pending.pop_front();
          in_data <= item.req;
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 4);
          end else begin
            burst_left--;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // ---------------- monitor and receiver stalls ----------------
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin : check_digest
    out_t exp_w;
    logic next_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("digest word with nothing expected: %h", out_data.digest_word);
          mismatches++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data.digest_word !== exp_w.digest_word) begin
            $error("digest_word: expected %h, got %h", exp_w.digest_word,
                   out_data.digest_word);
            mismatches++;
          end
          if (out_data.word_index !== exp_w.word_index) begin
            $error("word_index: expected %0d, got %0d", exp_w.word_index,
                   out_data.word_index);
            mismatches++;
          end
          if (out_data.last_word !== exp_w.last_word) begin
            $error("last_word: expected %0d, got %0d", exp_w.last_word,
                   out_data.last_word);
            mismatches++;
          end
          checked_words <= checked_words + 1;
        end
      end

      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end

      // one long hold-off while a digest waits, so the input backs up
      if (!hold_done && out_valid && checked_words >= 24) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end

      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        case (stall_mode)
          0: next_stall = 1'b0;
          1: next_stall = ($urandom_range(0, 9) < 3);
          default: next_stall = ($urandom_range(0, 9) < 7);
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // ---------------- watchdog ----------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request or digest word moved in %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------- stimulus and end of run ----------------
  task automatic add_req(logic [7:0] data, logic present, logic eom, bit drain = 1'b0);
    byte_req_t item;
    item.req.data_byte      = data;
    item.req.byte_present   = present;
    item.req.end_of_message = eom;
    item.drain_first        = drain;
    pending.push_back(item);
  endtask

  task automatic add_message(int len, bit drain);
    bit end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_req(8'($urandom_range(0, 255)), 1'b1,
              end_on_byte && (i == len - 1), drain && (i == 0));
    end
    if (!end_on_byte)
      add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
  endtask

  initial begin
    int len;
    int pick;
    int edge_lens [6] = '{55, 56, 57, 63, 64, 65};

    // empty message first, then idle, single-byte and short messages
    add_req(8'h5a, 1'b0, 1'b1);
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b0);
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'h61, 1'b1, 1'b0, 1'b1);
    add_req(8'h62, 1'b1, 1'b0);
    add_req(8'h63, 1'b1, 1'b1);
    add_req(8'h55, 1'b1, 1'b0);
    add_req(8'haa, 1'b0, 1'b0);
    add_req(8'haa, 1'b1, 1'b0);
    add_req(8'h80, 1'b0, 1'b1);
    add_req(8'h7f, 1'b0, 1'b1, 1'b1);

    while (pending.size() < RANDOM_REQS) begin
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        repeat ($urandom_range(1, 4)) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        continue;
      end
      if (pick < 5) len = $urandom_range(0, 12);
      else if (pick < 8) len = edge_lens[$urandom_range(0, 5)];
      else len = $urandom_range(13, 130);
      add_message(len, $urandom_range(0, 7) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending.size() != 0 || in_valid) @(negedge clk);
    while (predicted_words != checked_words) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (digest_q.size() != 0) begin
      $error("%0d digest words never arrived", digest_q.size());
      mismatches++;
    end
    $display("Hashed %0d messages from %0d requests (%0d needing an extra padding block),",
             msgs_done, reqs_sent, two_block_pads);
    $display("checked %0d digest words under random idling and one long output hold.",
             checked_words);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sha256md_pkg.sv
hw/rtl/sha256md_round.sv
hw/rtl/sha256_message_digest.sv
verif/sha256_message_digest_tb.sv
